// ----- src/tile_map_background_pixel_renderer_assert.svh -----
// assertion macros used by the tile map background renderer checker
`ifndef TILE_MAP_BACKGROUND_PIXEL_RENDERER_ASSERT_SVH
`define TILE_MAP_BACKGROUND_PIXEL_RENDERER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TMBG_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmbg assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define TMBG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmbg assertion failed");

`endif

// ----- src/tmbg_pkg.sv -----
// shared types and constants of the tile map background renderer
package tmbg_pkg;

    localparam int VMEM_BYTES      = 8192;
    localparam int ADDR_W          = $clog2(VMEM_BYTES);
    localparam int BANK_DEPTH      = VMEM_BYTES / 2;
    localparam int BANK_AW         = $clog2(BANK_DEPTH);
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_IDX_W       = 3;

    // video memory offsets of the tile maps
    localparam logic [ADDR_W-1:0] MAP_HI_OFS = ADDR_W'(13'h1C00);
    localparam logic [ADDR_W-1:0] MAP_LO_OFS = ADDR_W'(13'h1800);
    // bank index of the signed tile data origin minus 128 tiles (byte 0x0800)
    localparam logic [BANK_AW-1:0] SIGNED_IDX_BASE = BANK_AW'(12'h400);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISP_CTRL = 3'd0,
        CFG_VSCROLL   = 3'd1,
        CFG_HSCROLL   = 3'd2,
        CFG_PALETTE   = 3'd3
    } cfg_idx_t;

    typedef enum logic {
        REQ_WRITE  = 1'b0,
        REQ_RENDER = 1'b1
    } req_type_t;

    typedef struct packed {
        logic [7:0] disp_ctrl;
        logic [7:0] vscroll;
        logic [7:0] hscroll;
        logic [7:0] palette;
    } cfg_t;

    // classified item as it travels from front to back
    typedef struct packed {
        logic              is_render;
        logic [ADDR_W-1:0] addr;      // write offset or tile map entry offset
        logic [7:0]        wr_data;
        logic [2:0]        tile_row;
        logic [2:0]        tile_col;
        logic [7:0]        col;
        logic [7:0]        row;
    } cmd_t;

endpackage

// ----- src/tmbg_front.sv -----
// front end: accepts input beats and turns them into classified commands
module tmbg_front (
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        req_type,
    input  logic [tmbg_pkg::ADDR_W-1:0] mem_offset,
    input  logic [7:0]                  mem_byte,
    input  logic [7:0]                  screen_x,
    input  logic [7:0]                  screen_y,
    input  tmbg_pkg::cfg_t              cfg,
    input  logic                        queue_full,
    input  logic                        clearing,
    output logic                        push,
    output tmbg_pkg::cmd_t              cmd
);
    import tmbg_pkg::*;

    logic [7:0]        bg_x;
    logic [7:0]        bg_y;
    logic [ADDR_W-1:0] map_base;
    logic [ADDR_W-1:0] map_addr;

    assign in_ready = !queue_full && !clearing;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        bg_x     = screen_x + cfg.hscroll;
        bg_y     = screen_y + cfg.vscroll;
        map_base = cfg.disp_ctrl[3] ? MAP_HI_OFS : MAP_LO_OFS;
        map_addr = map_base + ADDR_W'({bg_y[7:3], bg_x[7:3]});

        cmd.is_render = (req_type == REQ_RENDER);
        cmd.addr      = (req_type == REQ_RENDER) ? map_addr : mem_offset;
        cmd.wr_data   = mem_byte;
        cmd.tile_row  = bg_y[2:0];
        cmd.tile_col  = bg_x[2:0];
        cmd.col       = screen_x;
        cmd.row       = screen_y;
    end

endmodule

// ----- src/tmbg_queue.sv -----
// short command queue between front and back
module tmbg_queue #(
    parameter int QUEUE_DEPTH = tmbg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tmbg_pkg::cmd_t din,
    input  logic           pop,
    output tmbg_pkg::cmd_t dout,
    output logic           full,
    output logic           empty
);
    import tmbg_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- src/tmbg_back.sv -----
// back end: video memory banks, clearing pass and the render pipeline
module tmbg_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tmbg_pkg::cfg_t cfg,
    input  tmbg_pkg::cmd_t head,
    input  logic           queue_empty,
    output logic           pop,
    output logic           clearing,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     pixel_shade,
    output logic [7:0]     pixel_col,
    output logic [7:0]     pixel_row
);
    import tmbg_pkg::*;

    localparam logic [BANK_AW-1:0] CLR_LAST = BANK_AW'(BANK_DEPTH - 1);

    // even and odd byte banks
    logic [7:0] ram_even [BANK_DEPTH];
    logic [7:0] ram_odd  [BANK_DEPTH];

    logic               clearing_reg;
    logic [BANK_AW-1:0] clr_idx_reg;

    logic               adv;
    logic               wr_cmd;
    logic               we_even;
    logic               we_odd;
    logic [BANK_AW-1:0] wr_idx;
    logic [7:0]         wr_byte;
    logic [BANK_AW-1:0] map_idx;

    logic [7:0] map_even_reg;
    logic [7:0] map_odd_reg;
    logic [7:0] plane_lo_reg;
    logic [7:0] plane_hi_reg;

    // stage 2: tile index available
    logic       s2_valid_reg;
    logic       s2_sel_reg;
    logic [2:0] s2_tile_row_reg;
    logic [2:0] s2_tile_col_reg;
    logic [7:0] s2_col_reg;
    logic [7:0] s2_row_reg;

    // stage 3: bitplane bytes available
    logic       s3_valid_reg;
    logic [2:0] s3_tile_col_reg;
    logic [7:0] s3_col_reg;
    logic [7:0] s3_row_reg;

    logic       out_valid_reg;
    logic [1:0] shade_reg;
    logic [7:0] col_reg;
    logic [7:0] row_reg;

    logic [7:0]         tile_idx;
    logic [BANK_AW-1:0] data_idx;
    logic [2:0]         bit_sel;
    logic [1:0]         pix_code;
    logic [1:0]         shade_next;

    assign clearing    = clearing_reg;
    assign adv         = !out_valid_reg || out_ready;
    assign pop         = adv && !queue_empty && !clearing_reg;
    assign wr_cmd      = pop && !head.is_render;
    assign we_even     = clearing_reg || (wr_cmd && !head.addr[0]);
    assign we_odd      = clearing_reg || (wr_cmd && head.addr[0]);
    assign wr_idx      = clearing_reg ? clr_idx_reg : head.addr[ADDR_W-1:1];
    assign wr_byte     = clearing_reg ? 8'h00 : head.wr_data;
    assign map_idx     = head.addr[ADDR_W-1:1];

    assign out_valid   = out_valid_reg;
    assign pixel_shade = shade_reg;
    assign pixel_col   = col_reg;
    assign pixel_row   = row_reg;

    // tile data address: both plane bytes share one bank index
    always_comb
    begin
        tile_idx = s2_sel_reg ? map_odd_reg : map_even_reg;
        if (cfg.disp_ctrl[4])
        begin
            data_idx = {1'b0, tile_idx, s2_tile_row_reg};
        end
        else
        begin
            data_idx = SIGNED_IDX_BASE + {1'b0, tile_idx ^ 8'h80, s2_tile_row_reg};
        end
    end

    always_comb
    begin
        bit_sel    = ~s3_tile_col_reg;
        pix_code   = {plane_hi_reg[bit_sel], plane_lo_reg[bit_sel]};
        shade_next = cfg.disp_ctrl[7] ? cfg.palette[{pix_code, 1'b0} +: 2] : 2'd0;
    end

    // read before write within a bank keeps the item order
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            map_even_reg <= ram_even[map_idx];
            plane_lo_reg <= ram_even[data_idx];
        end
        if (we_even)
        begin
            ram_even[wr_idx] <= wr_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            map_odd_reg  <= ram_odd[map_idx];
            plane_hi_reg <= ram_odd[data_idx];
        end
        if (we_odd)
        begin
            ram_odd[wr_idx] <= wr_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == CLR_LAST)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg  <= pop && head.is_render;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sel_reg      <= head.addr[0];
            s2_tile_row_reg <= head.tile_row;
            s2_tile_col_reg <= head.tile_col;
            s2_col_reg      <= head.col;
            s2_row_reg      <= head.row;
            s3_tile_col_reg <= s2_tile_col_reg;
            s3_col_reg      <= s2_col_reg;
            s3_row_reg      <= s2_row_reg;
            shade_reg       <= shade_next;
            col_reg         <= s3_col_reg;
            row_reg         <= s3_row_reg;
        end
    end

endmodule

// ----- src/tile_map_background_pixel_renderer.sv -----
// top level of the tile map background renderer: config registers and wiring
// Background renderer for a 2-bit-per-pixel tile map display. Input beats either
// store one byte into the 8 KiB video memory (req_type 0) or render one screen
// pixel (req_type 1); each render beat gives exactly one result beat, in order,
// with the palette-mapped shade (0 while display control bit 7 is clear) and the
// unscrolled screen column and row. Throughput is one item per clock while the
// output is not stalled and the clearing pass is over: the video memory is split
// into even and odd byte banks with two read ports each, so the tile map read and
// the two bitplane reads of different pixels run in separate pipeline stages at
// the same time. A render passes the queue, the tile map read, the bitplane read
// and the palette lookup into the output register before its result beat is
// valid; a stalled output freezes the back pipeline while the front keeps filling
// the queue. After reset a clearing pass zeroes the video memory, one entry of
// each bank per cycle, over all 4096 entries of each bank; in_ready stays low
// during the pass while config writes are taken as usual. Config writes are always
// accepted and must only be issued while no render is in flight.
module tile_map_background_pixel_renderer #(
    parameter int QUEUE_DEPTH = tmbg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // config write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tmbg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    // input channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           req_type,
    input  logic [tmbg_pkg::ADDR_W-1:0]    mem_offset,
    input  logic [7:0]                     mem_byte,
    input  logic [7:0]                     screen_x,
    input  logic [7:0]                     screen_y,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     pixel_shade,
    output logic [7:0]                     pixel_col,
    output logic [7:0]                     pixel_row
);
    import tmbg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;
    logic clearing;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // config registers never stall
    assign cfg_ready = 1'b1;

    // register decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DISP_CTRL: cfg_next.disp_ctrl = cfg_data;
                CFG_VSCROLL:   cfg_next.vscroll   = cfg_data;
                CFG_HSCROLL:   cfg_next.hscroll   = cfg_data;
                CFG_PALETTE:   cfg_next.palette   = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: takes a beat, adds scroll, picks the tile map entry
    tmbg_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .mem_offset (mem_offset),
        .mem_byte   (mem_byte),
        .screen_x   (screen_x),
        .screen_y   (screen_y),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .clearing   (clearing),
        .push       (push),
        .cmd        (push_cmd)
    );

    // decoupling queue so an output stall does not reach in_ready at once
    tmbg_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_cmd),
        .pop   (pop),
        .dout  (head_cmd),
        .full  (queue_full),
        .empty (queue_empty)
    );

    // back: memory writes, tile map and bitplane reads, palette lookup
    tmbg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (head_cmd),
        .queue_empty (queue_empty),
        .pop         (pop),
        .clearing    (clearing),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_shade (pixel_shade),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row)
    );

endmodule

// ----- src/tmbg_checker.sv -----
// port-level checker of the tile map background renderer and its bind
`include "tile_map_background_pixel_renderer_assert.svh"

module tmbg_checker #(
    parameter int QUEUE_DEPTH = tmbg_pkg::QUEUE_DEPTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       req_type,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] pixel_shade,
    input logic [7:0] pixel_col,
    input logic [7:0] pixel_row
);
    import tmbg_pkg::*;

    // queue slots plus the three back stages
    localparam int MAX_PENDING = QUEUE_DEPTH + 3;
    localparam int PW = $clog2(MAX_PENDING + 2);

    logic [PW-1:0] pending_reg;
    logic [PW-1:0] pending_next;
    logic          render_beat;
    logic          result_beat;
    logic [17:0]   out_beat;

    assign render_beat  = in_valid && in_ready && (req_type == REQ_RENDER);
    assign result_beat  = out_valid && out_ready;
    assign pending_next = pending_reg + PW'(render_beat) - PW'(result_beat);
    assign out_beat     = {pixel_shade, pixel_col, pixel_row};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `TMBG_ASSERT_NEXT(a_stall_keeps_valid, out_valid && !out_ready, out_valid)
    `TMBG_ASSERT_NEXT(a_stall_keeps_beat, out_valid && !out_ready, $stable(out_beat))
    `TMBG_ASSERT_IMPL(a_result_has_render, out_valid, pending_reg != '0)
    `TMBG_ASSERT_IMPL(a_pending_bounded, 1'b1, pending_reg <= PW'(MAX_PENDING))

endmodule

bind tile_map_background_pixel_renderer tmbg_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tmbg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_shade (pixel_shade),
    .pixel_col   (pixel_col),
    .pixel_row   (pixel_row)
);

// ----- test/tb_tile_map_background_pixel_renderer.sv -----
// self-checking testbench for the tile map background renderer with a built-in pixel predictor
module tb_tile_map_background_pixel_renderer;
    timeunit 1ns;
    timeprecision 1ps;

    import tmbg_pkg::*;

    localparam int CLK_HALF_NS   = 6;
    localparam int RESET_CYCLES  = 5;
    // the front queue, map read, plane read and output register lie between accept
    // and result; the settle time covers a write still in flight
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 65;
    // the timeout leaves room for the clearing pass and a normal run
    localparam int TIMEOUT_NS    = 5_000_000;

    // register indexes past the end of the list are ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd4;

    // display control bits
    localparam int LCD_ON       = 7;
    localparam int LCD_UNSIGNED = 4;
    localparam int LCD_MAP_HI   = 3;

    // signed tile data origin (0x9000) moved back by 128 tiles, as a video memory offset
    localparam logic [ADDR_W-1:0] SIGNED_TILE_ORIGIN = 13'h0800;

    typedef struct packed {
        logic [1:0] shade;
        logic [7:0] col;
        logic [7:0] row;
    } pixel_t;

    // dut ports, all inputs driven to known values from time zero
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [7:0]           cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic                 req_type    = REQ_WRITE;
    logic [ADDR_W-1:0]    mem_offset  = '0;
    logic [7:0]           mem_byte    = '0;
    logic [7:0]           screen_x    = '0;
    logic [7:0]           screen_y    = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [1:0]           pixel_shade;
    logic [7:0]           pixel_col;
    logic [7:0]           pixel_row;

    // predictor state: mirror of video memory and of the four registers
    logic [7:0] vram_image [VMEM_BYTES];
    logic [7:0] lcd_reg = 8'h00;
    logic [7:0] scy_reg = 8'h00;
    logic [7:0] scx_reg = 8'h00;
    logic [7:0] pal_reg = 8'h00;

    // pixels predicted for accepted render beats, oldest first
    pixel_t pending_pixels [$];

    int error_count = 0;
    int items_sent  = 0;
    int ready_hold  = 0;
    bit gaps_on     = 1'b1;
    bit stalls_on   = 1'b1;

    tile_map_background_pixel_renderer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .mem_offset  (mem_offset),
        .mem_byte    (mem_byte),
        .screen_x    (screen_x),
        .screen_y    (screen_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_shade (pixel_shade),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    // ------------------------------------------------------------------
    // pixel predictor
    // ------------------------------------------------------------------

    // tile map entry for a background position (already scrolled)
    function automatic logic [ADDR_W-1:0] map_entry_addr(logic [7:0] bx, logic [7:0] by);
        logic [ADDR_W-1:0] map_base;
        map_base = lcd_reg[LCD_MAP_HI] ? MAP_HI_OFS : MAP_LO_OFS;
        return map_base + ADDR_W'({by[7:3], bx[7:3]});
    endfunction

    // low bitplane byte of one row of a tile; the high plane follows it
    function automatic logic [ADDR_W-1:0] plane_row_addr(logic [7:0] tile, logic [2:0] line);
        logic [ADDR_W-1:0] base;
        if (lcd_reg[LCD_UNSIGNED])
            base = ADDR_W'({tile, 4'h0});
        else
            // flipping the sign bit turns the signed index into a count from -128
            base = SIGNED_TILE_ORIGIN + ADDR_W'({tile ^ 8'h80, 4'h0});
        return base + ADDR_W'({line, 1'b0});
    endfunction

    function automatic logic [1:0] background_shade(logic [7:0] sx, logic [7:0] sy);
        logic [7:0]        bx;
        logic [7:0]        by;
        logic [7:0]        tile;
        logic [7:0]        lo;
        logic [7:0]        hi;
        logic [ADDR_W-1:0] row_addr;
        logic [2:0]        bitpos;
        logic [1:0]        pix_code;
        // scroll wraps at 256 through the 8-bit sum
        bx       = sx + scx_reg;
        by       = sy + scy_reg;
        tile     = vram_image[map_entry_addr(bx, by)];
        row_addr = plane_row_addr(tile, by[2:0]);
        lo       = vram_image[row_addr];
        hi       = vram_image[row_addr + 1'b1];
        // leftmost pixel of a tile sits in bit 7
        bitpos   = 3'd7 - bx[2:0];
        pix_code = {hi[bitpos], lo[bitpos]};
        if (!lcd_reg[LCD_ON])
            return 2'd0;
        return pal_reg[{pix_code, 1'b0} +: 2];
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // one input beat; entered and left at a rising edge, valid stays high on return
    // so that back-to-back beats never drop it
    task automatic send_item(req_type_t req, logic [ADDR_W-1:0] ofs, logic [7:0] data,
                             logic [7:0] sx, logic [7:0] sy);
        pixel_t want;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        mem_offset <= ofs;
        mem_byte   <= data;
        screen_x   <= sx;
        screen_y   <= sy;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        // predict in accept order so writes and renders interleave exactly
        if (req == REQ_WRITE)
            vram_image[ofs] = data;
        else
        begin
            want.shade = background_shade(sx, sy);
            want.col   = sx;
            want.row   = sy;
            pending_pixels.push_back(want);
        end
    endtask

    // unused fields carry noise: the block must ignore them
    task automatic write_byte(logic [ADDR_W-1:0] ofs, logic [7:0] data);
        send_item(REQ_WRITE, ofs, data, 8'($urandom), 8'($urandom));
    endtask

    task automatic render(logic [7:0] sx, logic [7:0] sy);
        send_item(REQ_RENDER, ADDR_W'($urandom), 8'($urandom), sx, sy);
    endtask

    // write the map entry and both planes that the pixel at (sx, sy) will read
    task automatic paint_tile_row(logic [7:0] sx, logic [7:0] sy, logic [7:0] tile,
                                  logic [7:0] lo, logic [7:0] hi);
        logic [7:0]        bx;
        logic [7:0]        by;
        logic [ADDR_W-1:0] row_addr;
        bx       = sx + scx_reg;
        by       = sy + scy_reg;
        row_addr = plane_row_addr(tile, by[2:0]);
        write_byte(map_entry_addr(bx, by), tile);
        write_byte(row_addr, lo);
        write_byte(row_addr + 1'b1, hi);
    endtask

    // mostly on screen, sometimes anywhere in the 8-bit range
    function automatic logic [7:0] random_coord(int span);
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom);
        return 8'($urandom_range(0, span - 1));
    endfunction

    // sender stops and waits for every predicted pixel, then lets the pipeline settle
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // register writes, only issued with the block idle
    // ------------------------------------------------------------------

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DISP_CTRL: lcd_reg = value;
            CFG_VSCROLL:   scy_reg = value;
            CFG_HSCROLL:   scx_reg = value;
            CFG_PALETTE:   pal_reg = value;
            default: ;
        endcase
    endtask

    task automatic configure(logic [7:0] lcd, logic [7:0] scy, logic [7:0] scx, logic [7:0] pal);
        wait_for_results();
        write_reg(CFG_DISP_CTRL, lcd);
        write_reg(CFG_VSCROLL, scy);
        write_reg(CFG_HSCROLL, scx);
        write_reg(CFG_PALETTE, pal);
        // a beat to an index past the list must change nothing
        write_reg(CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 3)), 8'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // ready drops at random while stalls are enabled
    always @(posedge clk)
    begin
        if (!stalls_on)
        begin
            out_ready <= 1'b1;
            ready_hold = 0;
        end
        else if (ready_hold > 0)
            ready_hold--;
        else if ($urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            ready_hold = $urandom_range(0, 6);
        end
        else
        begin
            out_ready <= 1'b1;
            ready_hold = $urandom_range(0, 12);
        end
    end

    task automatic log_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // every result beat is matched against the oldest predicted pixel
    always @(posedge clk)
    begin : check_pixels
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
                log_error($sformatf("unexpected pixel beat: shade %0d col %0d row %0d",
                                    pixel_shade, pixel_col, pixel_row));
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_shade !== want.shade || pixel_col !== want.col ||
                    pixel_row !== want.row)
                    log_error($sformatf({"pixel mismatch: expected shade %0d col %0d row %0d,",
                                         " got shade %0d col %0d row %0d"},
                                        want.shade, want.col, want.row,
                                        pixel_shade, pixel_col, pixel_row));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // display off: every other control bit set, a fully lit tile, still shade 0
    task automatic test_display_off();
        configure(8'h7F, 8'h00, 8'h00, 8'hFF);
        paint_tile_row(8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        render(8'd0, 8'd0);
        render(8'd159, 8'd143);
        // off-screen corner still gives a beat, coordinates echoed
        render(8'd255, 8'd255);
    endtask

    // unsigned addressing, lower map, no scroll, identity palette
    task automatic test_unsigned_addressing();
        configure(8'h90, 8'h00, 8'h00, 8'hE4);
        // last tile: planes 0xaa / 0xcc give color ids 3, 2, 1, 0 across the first pixels
        paint_tile_row(8'd0, 8'd0, 8'hFF, 8'hAA, 8'hCC);
        for (int c = 0; c < 4; c++)
            render(8'(c), 8'd0);
        // highest offset, last entry of the upper map
        write_byte(13'h1FFF, 8'hFF);
    endtask

    // signed addressing, upper map, both scrolls at 255 so the position wraps
    task automatic test_signed_addressing();
        configure(8'h88, 8'hFF, 8'hFF, 8'h1B);
        // (1,1) scrolls to background (0,0); index 0x80 is tile -128
        paint_tile_row(8'd1, 8'd1, 8'h80, 8'h80, 8'h00);
        render(8'd1, 8'd1);
        // (0,0) scrolls to (255,255); index 0x7f is tile +127, row 7, bit 0
        paint_tile_row(8'd0, 8'd0, 8'h7F, 8'h01, 8'h01);
        render(8'd0, 8'd0);
    endtask

    // a run of mostly painted rows followed by renders inside the same tile row,
    // mixed with stray writes anywhere and renders of arbitrary pixels
    task automatic run_traffic_phase(logic [7:0] lcd, logic [7:0] scy, logic [7:0] scx,
                                     logic [7:0] pal, bit idle);
        int         target;
        int         kind;
        logic [7:0] sx;
        logic [7:0] sy;
        logic [7:0] bx;
        configure(lcd, scy, scx, pal);
        gaps_on   = idle;
        stalls_on = idle;
        target    = items_sent + PHASE_ITEMS;
        while (items_sent < target)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                sx = random_coord(160);
                sy = random_coord(144);
                paint_tile_row(sx, sy, 8'($urandom), 8'($urandom), 8'($urandom));
                // step back to the first column of the tile, then pick columns within it
                bx = sx + scx_reg;
                sx = sx - bx[2:0];
                repeat ($urandom_range(1, 4))
                    render(sx + 8'($urandom_range(0, 7)), sy);
            end
            else if (kind < 8)
                write_byte(ADDR_W'($urandom), 8'($urandom));
            else
                render(random_coord(160), random_coord(144));
        end
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        run_traffic_phase(8'h80, 8'h00, 8'h00, 8'h00, 1'b1);
        run_traffic_phase(8'h90, 8'h00, 8'h00, 8'hE4, 1'b1);
        repeat (4)
            run_traffic_phase(8'($urandom) | 8'h80, 8'($urandom), 8'($urandom),
                              8'($urandom), 1'b1);
        // control fully random, so the display may be off here
        run_traffic_phase(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        // closing stretch at full rate on both sides
        run_traffic_phase(8'($urandom) | 8'h80, 8'($urandom), 8'($urandom),
                          8'($urandom), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin : run_tests
        foreach (vram_image[i])
            vram_image[i] = 8'h00;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        // the first input beat waits out the clearing pass on in_ready
        test_display_off();
        test_unsigned_addressing();
        test_signed_addressing();
        test_random_traffic();
        wait_for_results();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
